[design/waveform_column_envelope_macros.svh]
`ifndef WAVEFORM_COLUMN_ENVELOPE_MACROS_SVH
`define WAVEFORM_COLUMN_ENVELOPE_MACROS_SVH

// The condition must never hold while the block is out of reset.
`define WCE_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// The consequence must hold in the cycle after the trigger, reset included.
`define WCE_ASSERT_AFTER(label, clk, trig, cond, msg) \
   label: assert property (@(posedge clk) (trig) |=> (cond)) else $error(msg);

`endif

[design/wce_pkg.sv]
`timescale 1ns / 1ps

package wce_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 20;
   localparam int MAX_COLUMNS = 256;

   localparam int COL_W    = 9;
   localparam int SUM_W    = 32;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int HEIGHT_W = 8;
   localparam int ROW_W    = 9;
   localparam int PANEL_W  = 8;
   localparam int ORIGIN_W = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = COUNT_BITS;

   localparam int JOB_QUEUE_DEPTH = 4;

   localparam logic OP_START  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BUFFER_LENGTH = 3'd0,
      REG_COLUMN_COUNT  = 3'd1,
      REG_PANEL_HEIGHT  = 3'd2,
      REG_X_ORIGIN      = 3'd3,
      REG_Y_ORIGIN      = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic                          opcode;
      logic signed [SAMPLE_BITS-1:0] sample;
   } wce_req_type;

   typedef struct packed {
      logic [ROW_W-1:0]    screen_column;
      logic [HEIGHT_W-1:0] column_height;
      logic [ROW_W-1:0]    first_row;
      logic [ROW_W-1:0]    last_row;
   } wce_rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] buffer_length;
      logic [COL_W-1:0]      column_count;
      logic [PANEL_W-1:0]    panel_height;
      logic [ORIGIN_W-1:0]   x_origin;
      logic [ORIGIN_W-1:0]   y_origin;
   } wce_cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0]      sum;
      logic [COUNT_BITS-1:0] bucket;
      logic [COL_W-1:0]      column;
   } wce_job_type;

   typedef struct packed {
      logic        valid;
      wce_job_type job;
   } wce_push_type;

   typedef struct packed {
      logic empty;
      logic full;
   } wce_queue_status_type;

endpackage

[design/waveform_column_envelope.sv]
// Waveform column envelope: reduces a stream of audio samples to one column per
// bucket for an overview panel.
// Configuration is written on the csr_ channel, which is always ready; write only
// while the block is idle. The req_ channel takes a start beat, which latches the
// bucket size, or a sample beat. A start beat with a non-zero column count holds
// req_ready low while a 20-step divider works out the bucket size; sample beats
// are then taken one per cycle while the queue has room.
// A sample beat that completes a bucket hands the column to a four-entry queue.
// The column unit divides the sum by the bucket size, halves the quotient and
// takes its square root; it works on one column at a time and takes the next
// column from the queue only when it is idle.
// When the queue is full, req_ready falls until the column unit frees an entry.
// A stalled receiver holds the result in the output register; the column unit
// waits behind it, and then the queue and the sample side.
// Reset clears the configuration to its defaults, empties the queue and drops
// any redraw in progress; no result is pending after reset.
`timescale 1ns / 1ps
`include "waveform_column_envelope_macros.svh"

module waveform_column_envelope
   import wce_pkg::*;
#(
   parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  wce_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output wce_rsp_type            rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   wce_cfg_type          cfg_ff, cfg_in;
   wce_push_type         job_push;
   wce_job_type          job_head;
   wce_queue_status_type queue_status;
   logic                 queue_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_BUFFER_LENGTH: cfg_in.buffer_length = csr_data[COUNT_BITS-1:0];
            REG_COLUMN_COUNT:  cfg_in.column_count  = csr_data[COL_W-1:0];
            REG_PANEL_HEIGHT:  cfg_in.panel_height  = csr_data[PANEL_W-1:0];
            REG_X_ORIGIN:      cfg_in.x_origin      = csr_data[ORIGIN_W-1:0];
            REG_Y_ORIGIN:      cfg_in.y_origin      = csr_data[ORIGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_length <= '0;
         cfg_ff.column_count  <= '0;
         cfg_ff.panel_height  <= PANEL_W'(1);
         cfg_ff.x_origin      <= '0;
         cfg_ff.y_origin      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .queue_full(queue_status.full),
      .push      (job_push)
   );

   wce_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .pop   (queue_pop),
      .head  (job_head),
      .status(queue_status)
   );

   wce_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (job_head),
      .queue_status(queue_status),
      .pop         (queue_pop),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   `WCE_ASSERT_NEVER(a_push_when_full, clock, reset, job_push.valid && queue_status.full, "column pushed into a full queue")
   `WCE_ASSERT_NEVER(a_pop_when_empty, clock, reset, queue_pop && queue_status.empty, "column taken from an empty queue")
   `WCE_ASSERT_AFTER(a_quiet_after_reset, clock, reset, !rsp_valid && !queue_pop, "result or column pending after reset")

endmodule

[design/wce_div.sv]
`timescale 1ns / 1ps

module wce_div
   import wce_pkg::*;
#(
   parameter int NUM_W = COUNT_BITS,
   parameter int DEN_W = COL_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_diff;
   logic             fits;

   assign rem_shift = {rem_ff, quot_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quot_in  = numerator;
         rem_in   = '0;
         den_in   = denominator;
         count_in = CNT_W'(NUM_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[NUM_W-2:0], fits};
         rem_in   = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

[design/wce_front.sv]
`timescale 1ns / 1ps

module wce_front
   import wce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  wce_req_type  req_data,
   input  wce_cfg_type  cfg,
   input  logic         queue_full,
   output wce_push_type push
);

   typedef enum logic [1:0] {
      F_READY  = 2'b01,
      F_DIVIDE = 2'b10
   } front_state_type;

   front_state_type       state_ff, state_in;
   logic [COUNT_BITS-1:0] bucket_ff, bucket_in;
   logic [COUNT_BITS-1:0] index_ff, index_in;
   logic [COUNT_BITS-1:0] fill_ff, fill_in;
   logic [COL_W-1:0]      column_ff, column_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  active_ff, active_in;

   logic                   accept;
   logic [COL_W-1:0]       limit;
   logic [SAMPLE_BITS-1:0] raw_bits;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SAMPLE_BITS-1:0] mag_used;
   logic [SUM_W-1:0]       sum_next;
   logic [COUNT_BITS-1:0]  index_next;
   logic [COUNT_BITS-1:0]  fill_next;
   logic [COL_W-1:0]       column_next;
   logic                   div_start;
   logic                   div_done;
   logic [COUNT_BITS-1:0]  div_quotient;

   assign req_ready = (state_ff == F_READY) && !queue_full;
   assign accept    = req_valid && req_ready;
   assign limit     = (cfg.column_count > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
                                                                : cfg.column_count;

   assign raw_bits = req_data.sample;
   assign mag      = raw_bits[SAMPLE_BITS-1]
                     ? (~raw_bits) + {{(SAMPLE_BITS-1){1'b0}}, 1'b1}
                     : raw_bits;
   assign mag_used = (index_ff < cfg.buffer_length) ? mag : '0;
   assign sum_next = sum_ff + {{(SUM_W-SAMPLE_BITS){1'b0}}, mag_used};

   assign index_next  = (&index_ff) ? index_ff : index_ff + 1'b1;
   assign fill_next   = (&fill_ff) ? fill_ff : fill_ff + 1'b1;
   assign column_next = column_ff + 1'b1;

   assign div_start = accept && (req_data.opcode == OP_START) && (limit != '0);

   wce_div #(
      .NUM_W(COUNT_BITS),
      .DEN_W(COL_W)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .numerator  (cfg.buffer_length),
      .denominator(limit),
      .done       (div_done),
      .quotient   (div_quotient)
   );

   always_comb begin
      state_in        = state_ff;
      bucket_in       = bucket_ff;
      index_in        = index_ff;
      fill_in         = fill_ff;
      column_in       = column_ff;
      sum_in          = sum_ff;
      active_in       = active_ff;
      push.valid      = 1'b0;
      push.job.sum    = sum_next;
      push.job.bucket = bucket_ff;
      push.job.column = column_ff;
      case (state_ff)
         F_READY: begin
            if (accept) begin
               if (req_data.opcode == OP_START) begin
                  index_in  = '0;
                  fill_in   = '0;
                  column_in = '0;
                  sum_in    = '0;
                  active_in = 1'b1;
                  if (limit == '0) begin
                     bucket_in = COUNT_BITS'(1);
                  end else begin
                     state_in = F_DIVIDE;
                  end
               end else if (active_ff) begin
                  if (column_ff >= limit) begin
                     active_in = 1'b0;
                  end else begin
                     sum_in   = sum_next;
                     index_in = index_next;
                     fill_in  = fill_next;
                     if (fill_next >= bucket_ff) begin
                        push.valid = 1'b1;
                        column_in  = column_next;
                        sum_in     = '0;
                        fill_in    = '0;
                        if (column_next >= limit) begin
                           active_in = 1'b0;
                        end
                     end
                  end
               end
            end
         end
         F_DIVIDE: begin
            if (div_done) begin
               bucket_in = (div_quotient == '0) ? COUNT_BITS'(1) : div_quotient;
               state_in  = F_READY;
            end
         end
         default: begin
            state_in = F_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_READY;
         bucket_ff <= COUNT_BITS'(1);
         index_ff  <= '0;
         fill_ff   <= '0;
         column_ff <= '0;
         sum_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bucket_ff <= bucket_in;
         index_ff  <= index_in;
         fill_ff   <= fill_in;
         column_ff <= column_in;
         sum_ff    <= sum_in;
         active_ff <= active_in;
      end
   end

endmodule

[design/wce_queue.sv]
`timescale 1ns / 1ps

module wce_queue
   import wce_pkg::*;
#(
   parameter int DEPTH = JOB_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wce_push_type         push,
   input  logic                 pop,
   output wce_job_type          head,
   output wce_queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   wce_job_type      slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.job;
      end
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

endmodule

[design/wce_back.sv]
`timescale 1ns / 1ps

module wce_back
   import wce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  wce_job_type          head,
   input  wce_queue_status_type queue_status,
   output logic                 pop,
   input  wce_cfg_type          cfg,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wce_rsp_type          rsp_data
);

   localparam int REM_W  = ROOT_W + 2;
   localparam int STEP_W = $clog2(ROOT_W);

   typedef enum logic [3:0] {
      B_IDLE   = 4'b0001,
      B_DIVIDE = 4'b0010,
      B_ROOT   = 4'b0100,
      B_EMIT   = 4'b1000
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [SUM_W-1:0]  operand_ff, operand_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   wce_rsp_type       rsp_data_ff, rsp_data_in;

   logic                 div_done;
   logic [SUM_W-1:0]     div_quotient;
   logic [REM_W-1:0]     rem_cat;
   logic [REM_W-1:0]     trial;
   logic                 take;
   logic [HEIGHT_W-1:0]  height;
   logic [PANEL_W-1:0]   panel;
   logic [PANEL_W-1:0]   mid;
   logic [PANEL_W-1:0]   panel_last;
   logic [PANEL_W-1:0]   top;
   logic [PANEL_W:0]     bot_sum;
   logic [PANEL_W-1:0]   bot;
   wce_rsp_type          result;

   assign pop = (state_ff == B_IDLE) && !queue_status.empty;

   wce_div #(
      .NUM_W(SUM_W),
      .DEN_W(COUNT_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (pop),
      .numerator  (head.sum),
      .denominator(head.bucket),
      .done       (div_done),
      .quotient   (div_quotient)
   );

   assign rem_cat = {rem_ff[REM_W-3:0], operand_ff[SUM_W-1:SUM_W-2]};
   assign trial   = {root_ff, 2'b01};
   assign take    = rem_cat >= trial;

   assign height     = (|root_ff[ROOT_W-1:HEIGHT_W]) ? {HEIGHT_W{1'b1}}
                                                     : root_ff[HEIGHT_W-1:0];
   assign panel      = (cfg.panel_height == '0) ? PANEL_W'(1) : cfg.panel_height;
   assign mid        = panel >> 1;
   assign panel_last = panel - 1'b1;
   assign top        = (mid > height) ? mid - height : '0;
   assign bot_sum    = {1'b0, mid} + {1'b0, height};
   assign bot        = (bot_sum > {1'b0, panel_last}) ? panel_last : bot_sum[PANEL_W-1:0];

   assign result.screen_column = ROW_W'(cfg.x_origin) + column_ff;
   assign result.column_height = height;
   assign result.first_row     = ROW_W'(cfg.y_origin) + ROW_W'(top);
   assign result.last_row      = ROW_W'(cfg.y_origin) + ROW_W'(bot);

   always_comb begin
      state_in     = state_ff;
      column_in    = column_ff;
      operand_in   = operand_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop) begin
               column_in = head.column;
               state_in  = B_DIVIDE;
            end
         end
         B_DIVIDE: begin
            if (div_done) begin
               operand_in = {1'b0, div_quotient[SUM_W-1:1]};
               root_in    = '0;
               rem_in     = '0;
               step_in    = STEP_W'(ROOT_W - 1);
               state_in   = B_ROOT;
            end
         end
         B_ROOT: begin
            operand_in = {operand_ff[SUM_W-3:0], 2'b00};
            root_in    = {root_ff[ROOT_W-2:0], take};
            rem_in     = take ? rem_cat - trial : rem_cat;
            step_in    = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      column_ff   <= column_in;
      operand_ff  <= operand_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[tb/sv/waveform_column_envelope_tb.sv]
`timescale 1ns / 1ps

module waveform_column_envelope_tb;
   import wce_pkg::*;

   localparam int LIMIT_CYCLES  = 2_000_000;
   localparam int SETTLE_CYCLES = 120;
   localparam int LIVE_TARGET   = 1350;
   localparam int COLUMN_TARGET = 48;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   wce_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   wce_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // Predicted state of the block and its live configuration.
   wce_cfg_type           panel_cfg;
   logic [COUNT_BITS-1:0] bucket_len;
   logic [COUNT_BITS-1:0] stream_pos;
   logic [COUNT_BITS-1:0] bucket_count;
   logic [COL_W-1:0]      column_no;
   logic [SUM_W-1:0]      level_sum;
   logic                  drawing;

   wce_rsp_type columns_due[$];
   wce_req_type pending[$];

   int sent_count   = 0;
   int taken_count  = 0;
   int live_items   = 0;
   int columns_seen = 0;
   int errors       = 0;
   int cycle_count  = 0;
   int send_gap     = 0;
   int hold_left    = 0;
   bit quiet        = 1'b0;

   waveform_column_envelope DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [ROOT_W-1:0] floor_root(input logic [SUM_W-1:0] value);
      logic [ROOT_W-1:0] root;
      logic [ROOT_W-1:0] trial;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (ROOT_W'(1) << b);
         if (64'(trial) * 64'(trial) <= 64'(value))
            root = trial;
      end
      return root;
   endfunction

   function automatic void envelope_step(input wce_req_type item);
      logic [COL_W-1:0]       limit;
      logic [SAMPLE_BITS:0]   mag;
      logic [SUM_W-1:0]       mean;
      logic [ROOT_W-1:0]      root;
      logic [HEIGHT_W-1:0]    h;
      logic [ROW_W-1:0]       ph;
      logic [ROW_W-1:0]       mid;
      logic [ROW_W-1:0]       top;
      logic [ROW_W-1:0]       bot;
      wce_rsp_type            col;
      limit = (panel_cfg.column_count > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
                                                              : panel_cfg.column_count;
      if (item.opcode == OP_START) begin
         bucket_len = (limit != 0) ? COUNT_BITS'(panel_cfg.buffer_length / limit) : '0;
         if (bucket_len == 0)
            bucket_len = COUNT_BITS'(1);
         stream_pos   = '0;
         bucket_count = '0;
         column_no    = '0;
         level_sum    = '0;
         drawing      = 1'b1;
         live_items++;
         return;
      end
      if (!drawing)
         return;
      live_items++;
      if (column_no >= limit) begin
         drawing = 1'b0;
         return;
      end
      mag = item.sample[SAMPLE_BITS-1] ? {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, item.sample}
                                       : {1'b0, item.sample};
      if (stream_pos >= panel_cfg.buffer_length)
         mag = '0;
      level_sum = level_sum + SUM_W'(mag);
      if (stream_pos != '1)
         stream_pos++;
      if (bucket_count != '1)
         bucket_count++;
      if (bucket_count < bucket_len)
         return;
      mean = level_sum / SUM_W'(bucket_len);
      root = floor_root(mean >> 1);
      h    = (root > ROOT_W'(255)) ? '1 : HEIGHT_W'(root);
      ph   = (panel_cfg.panel_height != 0) ? ROW_W'(panel_cfg.panel_height) : ROW_W'(1);
      mid  = ph >> 1;
      top  = (mid > ROW_W'(h)) ? mid - ROW_W'(h) : '0;
      bot  = mid + ROW_W'(h);
      if (bot > ph - ROW_W'(1))
         bot = ph - ROW_W'(1);
      col.screen_column = ROW_W'(panel_cfg.x_origin + column_no);
      col.column_height = h;
      col.first_row     = ROW_W'(panel_cfg.y_origin + top);
      col.last_row      = ROW_W'(panel_cfg.y_origin + bot);
      columns_due.push_back(col);
      column_no++;
      level_sum    = '0;
      bucket_count = '0;
      if (column_no >= limit)
         drawing = 1'b0;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int roll;
      roll = $urandom_range(0, 99);
      case (roll % 4)
         0: return (roll < 12) ? 16'h8000 : SAMPLE_BITS'($urandom());
         1: return (roll < 12) ? 16'h7FFF : SAMPLE_BITS'($urandom_range(0, 511) - 256);
         2: return (roll < 12) ? 16'h0000 : SAMPLE_BITS'($urandom());
         default: return (roll < 12) ? 16'hFFFF : SAMPLE_BITS'($urandom());
      endcase
   endfunction

   function automatic void queue_item(input logic op, input logic [SAMPLE_BITS-1:0] value);
      wce_req_type item;
      item.opcode = op;
      item.sample = value;
      pending.push_back(item);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] with_junk(input logic [CSR_DATA_W-1:0] value,
                                                       input int width);
      logic [CSR_DATA_W-1:0] high;
      high = CSR_DATA_W'($urandom()) << width;
      return ($urandom_range(0, 7) == 0) ? (value | high) : value;
   endfunction

   task automatic check_field(input string name, input logic [ROW_W-1:0] want,
                              input logic [ROW_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_panel(input logic [CSR_DATA_W-1:0] buf_len,
                                input logic [CSR_DATA_W-1:0] cols,
                                input logic [CSR_DATA_W-1:0] height,
                                input logic [CSR_DATA_W-1:0] x_org,
                                input logic [CSR_DATA_W-1:0] y_org);
      write_reg(REG_BUFFER_LENGTH, buf_len);
      write_reg(REG_COLUMN_COUNT, with_junk(cols, COL_W));
      write_reg(REG_PANEL_HEIGHT, with_junk(height, PANEL_W));
      write_reg(REG_X_ORIGIN, with_junk(x_org, ORIGIN_W));
      write_reg(REG_Y_ORIGIN, with_junk(y_org, ORIGIN_W));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Holds the sender back until every column has arrived and the column unit has gone quiet.
   task automatic drain();
      while (pending.size() != 0 || sent_count != taken_count || columns_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset && sent_count == taken_count) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending.size() != 0) begin
            req_data  <= pending.pop_front();
            req_valid <= 1'b1;
            sent_count++;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            hold_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      wce_rsp_type want;
      if (!reset) begin
         cycle_count++;
         if (cycle_count > LIMIT_CYCLES) begin
            $display("** waveform_column_envelope: FAILED **");
            $finish;
         end else begin
            if (csr_valid && csr_ready) begin
               case (csr_reg_type'(csr_index))
                  REG_BUFFER_LENGTH: panel_cfg.buffer_length = csr_data;
                  REG_COLUMN_COUNT:  panel_cfg.column_count  = csr_data[COL_W-1:0];
                  REG_PANEL_HEIGHT:  panel_cfg.panel_height  = csr_data[PANEL_W-1:0];
                  REG_X_ORIGIN:      panel_cfg.x_origin      = csr_data[ORIGIN_W-1:0];
                  REG_Y_ORIGIN:      panel_cfg.y_origin      = csr_data[ORIGIN_W-1:0];
                  default: ;
               endcase
            end
            if (req_valid && req_ready) begin
               envelope_step(req_data);
               taken_count++;
            end
            if (rsp_valid && rsp_ready) begin
               if (columns_due.size() == 0) begin
                  $display("%0t: unexpected column, expected none, got %p", $time, rsp_data);
                  errors++;
               end else begin
                  want = columns_due.pop_front();
                  columns_seen++;
                  check_field("screen_column", want.screen_column, rsp_data.screen_column);
                  check_field("column_height", ROW_W'(want.column_height),
                              ROW_W'(rsp_data.column_height));
                  check_field("first_row", want.first_row, rsp_data.first_row);
                  check_field("last_row", want.last_row, rsp_data.last_row);
               end
            end
         end
      end
   end

   initial begin
      int cols;
      int limit;
      int bucket;
      int total;
      int count;
      int roll;
      int buf_len;
      int height;
      int x_org;
      int y_org;
      panel_cfg    = '0;
      panel_cfg.panel_height = 8'd1;
      bucket_len   = COUNT_BITS'(1);
      stream_pos   = '0;
      bucket_count = '0;
      column_no    = '0;
      level_sum    = '0;
      drawing      = 1'b0;
      cols    = 0;
      buf_len = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset configuration a sample before any start is dropped, and a start with
      // no columns ends the redraw on the following sample.
      queue_item(OP_SAMPLE, 16'h1234);
      queue_item(OP_START, 16'h0000);
      queue_item(OP_SAMPLE, 16'h7FFF);
      queue_item(OP_SAMPLE, 16'h8000);
      drain();

      // One-sample buckets at the sample extremes, a zero panel height and the widest x origin.
      program_panel(20'd4, 20'd4, 20'd0, 20'd255, 20'd191);
      queue_item(OP_START, 16'hFFFF);
      queue_item(OP_SAMPLE, 16'h8000);
      queue_item(OP_SAMPLE, 16'h7FFF);
      queue_item(OP_SAMPLE, 16'h0000);
      queue_item(OP_SAMPLE, 16'hFFFF);
      queue_item(OP_SAMPLE, 16'h0001);
      drain();

      // A column count beyond the maximum, and a start that cuts a bucket short.
      program_panel(20'd512, 20'd300, 20'd192, 20'd0, 20'd0);
      queue_item(OP_START, 16'h0000);
      queue_item(OP_SAMPLE, 16'h7FFF);
      queue_item(OP_SAMPLE, 16'h8000);
      queue_item(OP_SAMPLE, 16'h0064);
      queue_item(OP_START, 16'h0000);
      queue_item(OP_SAMPLE, 16'h0005);
      queue_item(OP_SAMPLE, 16'hFFF9);
      drain();

      // The buffer shrinks mid-redraw, so the last sample of the bucket lies beyond it.
      program_panel(20'd3, 20'd300, 20'd192, 20'd17, 20'd0);
      queue_item(OP_SAMPLE, 16'h03E8);
      queue_item(OP_SAMPLE, 16'hF830);
      drain();

      program_panel(20'hFFFFF, 20'd256, 20'd255, 20'd128, 20'd255);
      queue_item(OP_START, 16'h0000);
      queue_item(OP_SAMPLE, 16'h7FFF);
      queue_item(OP_SAMPLE, 16'h8000);
      queue_item(OP_SAMPLE, 16'h4321);
      drain();

      while (live_items < LIVE_TARGET || columns_seen < COLUMN_TARGET) begin
         drain();
         quiet = ($urandom_range(0, 4) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            count = $urandom_range(1, 24);
            for (int n = 0; n < count; n++)
               queue_item(OP_SAMPLE, pick_sample());
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
               cols = 0;
            else if (roll < 16)
               cols = $urandom_range(256, 511);
            else if (roll < 20)
               cols = 1;
            else
               cols = $urandom_range(2, 12);
            limit = (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
            roll = $urandom_range(0, 99);
            if (limit == 0 || roll < 5)
               buf_len = $urandom_range(0, 20'hFFFFF);
            else if (roll < 15)
               buf_len = $urandom_range(0, limit - 1);
            else begin
               bucket  = (limit >= 64) ? 1 : $urandom_range(1, 6);
               buf_len = limit * bucket + $urandom_range(0, limit - 1);
            end
            roll = $urandom_range(0, 99);
            height = (roll < 5) ? 0 : (roll < 10) ? 255 : (roll < 15) ? 1
                                                     : $urandom_range(1, 192);
            roll = $urandom_range(0, 99);
            x_org = (roll < 10) ? 255 : (roll < 20) ? 0 : $urandom_range(0, 255);
            roll = $urandom_range(0, 99);
            y_org = (roll < 10) ? 255 : (roll < 20) ? 0 : $urandom_range(0, 191);
            program_panel(CSR_DATA_W'(buf_len), CSR_DATA_W'(cols), CSR_DATA_W'(height),
                          CSR_DATA_W'(x_org), CSR_DATA_W'(y_org));

            bucket = (limit != 0) ? buf_len / limit : 0;
            if (bucket == 0)
               bucket = 1;
            total = (limit != 0) ? limit * bucket : 1;
            if (total > 400)
               total = 400;
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
               count = $urandom_range(1, 24);
               for (int n = 0; n < count; n++)
                  queue_item(OP_SAMPLE, pick_sample());
            end else if (roll < 22) begin
               count = $urandom_range(1, 16);
               for (int n = 0; n < count; n++)
                  queue_item(($urandom_range(0, 1) == 0) ? OP_START : OP_SAMPLE, pick_sample());
            end else begin
               queue_item(OP_START, pick_sample());
               count = (roll < 80) ? total + $urandom_range(0, 3) : $urandom_range(1, total);
               for (int n = 0; n < count; n++) begin
                  if ($urandom_range(0, 49) == 0)
                     queue_item(OP_START, pick_sample());
                  else
                     queue_item(OP_SAMPLE, pick_sample());
               end
            end
         end
      end

      drain();
      if (errors == 0) begin
         $display("** waveform_column_envelope: PASSED **");
      end else begin
         $display("** waveform_column_envelope: FAILED **");
      end
      $finish;
   end

endmodule
